// ===== sv/channel_to_modbus_write_framer_unit_macros.svh =====
// assertion macros shared by the framer modules
// expects clk and rst_n in the scope of use
`ifndef CHANNEL_TO_MODBUS_WRITE_FRAMER_UNIT_MACROS_SVH
`define CHANNEL_TO_MODBUS_WRITE_FRAMER_UNIT_MACROS_SVH

// condition holds at every edge out of reset
`define CMWF_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent implies consequent at the next edge
`define CMWF_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/cmwf_pkg.sv =====
// types, constants and crc helper for the channel to modbus write framer
// no dependencies
`timescale 1ns / 1ps

package cmwf_pkg;

    localparam int DRIVE_W = 16;

    localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
    localparam logic [15:0] CRC_SEED          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic signed [16:0] CHANNEL_CENTER = 17'sd1500;
    // ceil(2^19 / 9), exact quotient for dividends below 2^16
    localparam logic [15:0] DIV9_RECIP        = 16'd58255;
    localparam int          DIV9_SHIFT        = 19;

    localparam logic [2:0] BYTE_SLAVE    = 3'd0;
    localparam logic [2:0] BYTE_FUNC     = 3'd1;
    localparam logic [2:0] BYTE_REG_HI   = 3'd2;
    localparam logic [2:0] BYTE_REG_LO   = 3'd3;
    localparam logic [2:0] BYTE_VALUE_HI = 3'd4;
    localparam logic [2:0] BYTE_VALUE_LO = 3'd5;
    localparam logic [2:0] BYTE_CRC_LO   = 3'd6;
    localparam logic [2:0] BYTE_CRC_HI   = 3'd7;

    typedef enum logic [2:0] {
        REG_SLAVE_ADDRESS    = 3'd0,
        REG_REGISTER_ADDRESS = 3'd1,
        REG_CHANNEL_MIN      = 3'd2,
        REG_CHANNEL_MAX      = 3'd3,
        REG_CHANNEL_MID      = 3'd4,
        REG_DEADBAND         = 3'd5,
        REG_DRIVE_SCALE      = 3'd6,
        REG_DRIVE_LIMIT      = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]         slave_address;
        logic [15:0]        register_address;
        logic signed [15:0] channel_min;
        logic signed [15:0] channel_max;
        logic signed [15:0] channel_mid;
        logic [14:0]        deadband;
        logic [7:0]         drive_scale;
        logic [14:0]        drive_limit;
    } cfg_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/cmwf_if.sv =====
// handshake interfaces for command input and frame byte output
// no dependencies
`timescale 1ns / 1ps

interface cmwf_cmd_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] raw_value;

    modport source (output valid, output kind, output raw_value, input ready);
    modport sink   (input valid, input kind, input raw_value, output ready);
endinterface

interface cmwf_byte_if;
    logic               valid;
    logic               ready;
    logic [7:0]         frame_byte;
    logic [2:0]         byte_index;
    logic               last_byte;
    logic signed [15:0] drive_value;

    modport source (output valid, output frame_byte, output byte_index,
                    output last_byte, output drive_value, input ready);
    modport sink   (input valid, input frame_byte, input byte_index,
                    input last_byte, input drive_value, output ready);
endinterface

// ===== sv/cmwf_front.sv =====
// front pipeline: clamp, deadband, divide by nine, scale, saturate
// depends on cmwf_pkg, cmwf_if and the macros header
`timescale 1ns / 1ps
`include "channel_to_modbus_write_framer_unit_macros.svh"

module cmwf_front
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cmwf_pkg::cfg_t                       cfg,
    cmwf_cmd_if.sink                             cmd,
    input  logic                                 q_full,
    output logic                                 push_valid,
    output logic signed [cmwf_pkg::DRIVE_W-1:0]  push_drive
);

    logic               adv;
    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic               s1_stop_reg, s2_stop_reg, s3_stop_reg, s4_stop_reg;
    logic signed [15:0] s1_v_reg, s2_v_reg;
    logic signed [15:0] s2_v_next;
    logic               s3_neg_reg;
    logic [31:0]        s3_prod_reg;
    logic [31:0]        s3_prod_next;
    logic               s3_neg_next;
    logic signed [21:0] s4_t_reg;
    logic signed [21:0] s4_t_next;

    logic signed [16:0] diff;
    logic [16:0]        adiff;
    logic signed [16:0] centered;
    logic [16:0]        acent;
    logic [11:0]        quot;
    logic signed [12:0] squot;
    logic signed [21:0] lim_pos;
    logic signed [21:0] lim_neg;

    assign adv       = !(s4_valid_reg && q_full);
    assign cmd.ready = adv;

    // clamp and deadband
    always_comb
    begin
        diff  = 17'(s1_v_reg) - 17'(cfg.channel_mid);
        adiff = diff[16] ? 17'(-diff) : 17'(diff);
        priority if (s1_v_reg > cfg.channel_max)
        begin
            s2_v_next = cfg.channel_max;
        end
        else if (s1_v_reg < cfg.channel_min)
        begin
            s2_v_next = cfg.channel_min;
        end
        else if (adiff < {2'b00, cfg.deadband})
        begin
            s2_v_next = cfg.channel_mid;
        end
        else
        begin
            s2_v_next = s1_v_reg;
        end
    end

    // divide magnitude by nine through the reciprocal
    always_comb
    begin
        centered     = 17'(s2_v_reg) - cmwf_pkg::CHANNEL_CENTER;
        s3_neg_next  = centered[16];
        acent        = s3_neg_next ? 17'(-centered) : 17'(centered);
        s3_prod_next = acent[15:0] * cmwf_pkg::DIV9_RECIP;
    end

    // restore sign and scale
    always_comb
    begin
        quot      = s3_prod_reg[cmwf_pkg::DIV9_SHIFT +: 12];
        squot     = s3_neg_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
        s4_t_next = 22'(squot) * 22'($signed({1'b0, cfg.drive_scale}));
    end

    // saturate, or force zero for a stop command
    always_comb
    begin
        lim_pos    = $signed({7'b0, cfg.drive_limit});
        lim_neg    = -lim_pos;
        push_valid = s4_valid_reg && !q_full;
        priority if (s4_stop_reg)
        begin
            push_drive = '0;
        end
        else if (s4_t_reg > lim_pos)
        begin
            push_drive = lim_pos[15:0];
        end
        else if (s4_t_reg < lim_neg)
        begin
            push_drive = lim_neg[15:0];
        end
        else
        begin
            push_drive = s4_t_reg[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= cmd.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_stop_reg <= cmd.kind;
            s1_v_reg    <= $signed(cmd.raw_value);
            s2_stop_reg <= s1_stop_reg;
            s2_v_reg    <= s2_v_next;
            s3_stop_reg <= s2_stop_reg;
            s3_neg_reg  <= s3_neg_next;
            s3_prod_reg <= s3_prod_next;
            s4_stop_reg <= s3_stop_reg;
            s4_t_reg    <= s4_t_next;
        end
    end

    `CMWF_ASSERT_NEXT(a_front_hold, s4_valid_reg && q_full,
                      s4_valid_reg && $stable(s4_t_reg) && $stable(s4_stop_reg),
                      "front result changed while queue full")

endmodule

// ===== sv/cmwf_queue.sv =====
// small fifo of drive values between front and back
// depends on cmwf_pkg and the macros header
`timescale 1ns / 1ps
`include "channel_to_modbus_write_framer_unit_macros.svh"

module cmwf_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  logic signed [cmwf_pkg::DRIVE_W-1:0]  push_drive,
    output logic                                 full,
    output logic                                 q_valid,
    output logic signed [cmwf_pkg::DRIVE_W-1:0]  q_drive,
    input  logic                                 pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    logic signed [cmwf_pkg::DRIVE_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = count_reg == DEPTH_CNT;
    assign q_valid = count_reg != '0;
    assign q_drive = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_drive;
        end
    end

    `CMWF_ASSERT_ALWAYS(a_queue_bound, count_reg <= DEPTH_CNT, "queue count overflow")
    `CMWF_ASSERT_NEXT(a_queue_grow, do_push && !do_pop,
                      count_reg == $past(count_reg) + 1'b1, "queue count lost a push")

endmodule

// ===== sv/cmwf_back.sv =====
// back end: serializes one modbus write frame per drive value with running crc
// depends on cmwf_pkg, cmwf_if and the macros header
`timescale 1ns / 1ps
`include "channel_to_modbus_write_framer_unit_macros.svh"

module cmwf_back
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cmwf_pkg::cfg_t                       cfg,
    input  logic                                 q_valid,
    input  logic signed [cmwf_pkg::DRIVE_W-1:0]  q_drive,
    output logic                                 pop,
    cmwf_byte_if.source                          frame
);

    logic               active_reg, active_next;
    logic [2:0]         idx_reg, idx_next;
    logic [15:0]        crc_reg, crc_next;
    logic signed [15:0] drive_reg, drive_next;
    logic               fire;
    logic [7:0]         cur_byte;

    always_comb
    begin
        unique case (idx_reg)
            cmwf_pkg::BYTE_SLAVE:    cur_byte = cfg.slave_address;
            cmwf_pkg::BYTE_FUNC:     cur_byte = cmwf_pkg::FUNC_WRITE_SINGLE;
            cmwf_pkg::BYTE_REG_HI:   cur_byte = cfg.register_address[15:8];
            cmwf_pkg::BYTE_REG_LO:   cur_byte = cfg.register_address[7:0];
            cmwf_pkg::BYTE_VALUE_HI: cur_byte = drive_reg[15:8];
            cmwf_pkg::BYTE_VALUE_LO: cur_byte = drive_reg[7:0];
            cmwf_pkg::BYTE_CRC_LO:   cur_byte = crc_reg[7:0];
            cmwf_pkg::BYTE_CRC_HI:   cur_byte = crc_reg[15:8];
        endcase
    end

    assign frame.valid       = active_reg;
    assign frame.frame_byte  = cur_byte;
    assign frame.byte_index  = idx_reg;
    assign frame.last_byte   = idx_reg == cmwf_pkg::BYTE_CRC_HI;
    assign frame.drive_value = drive_reg;

    assign fire = active_reg && frame.ready;
    assign pop  = !active_reg || (fire && idx_reg == cmwf_pkg::BYTE_CRC_HI);

    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        crc_next    = crc_reg;
        drive_next  = drive_reg;
        priority if (pop)
        begin
            active_next = q_valid;
            idx_next    = cmwf_pkg::BYTE_SLAVE;
            crc_next    = cmwf_pkg::CRC_SEED;
            drive_next  = q_drive;
        end
        else if (fire)
        begin
            idx_next = idx_reg + 3'd1;
            if (idx_reg < cmwf_pkg::BYTE_CRC_LO)
            begin
                crc_next = cmwf_pkg::crc16_byte(crc_reg, cur_byte);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= cmwf_pkg::BYTE_SLAVE;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg   <= crc_next;
        drive_reg <= drive_next;
    end

    `CMWF_ASSERT_NEXT(a_back_stall, active_reg && !frame.ready,
                      active_reg && $stable(idx_reg) && $stable(drive_reg),
                      "frame byte moved while stalled")
    `CMWF_ASSERT_NEXT(a_back_step, fire && idx_reg != cmwf_pkg::BYTE_CRC_HI,
                      active_reg && idx_reg == $past(idx_reg) + 3'd1,
                      "frame byte skipped or dropped")

endmodule

// ===== sv/channel_to_modbus_write_framer_unit.sv =====
// a command passes the front stages, then the drive queue, then the back end's frame registers
// the back end emits one frame byte a cycle while the receiver is ready, eight bytes per command
// the 4-stage front pipeline and the drive queue let commands enter back to back meanwhile, until the queue fills
// reset: rst_n async low clears pipeline, queue and frame state, restores register defaults
`timescale 1ns / 1ps

module channel_to_modbus_write_framer_unit
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    cmwf_cmd_if.sink    cmd,
    cmwf_byte_if.source frame
);

    cmwf_pkg::cfg_t cfg_reg;
    logic           q_full;
    logic           push_valid;
    logic           q_valid;
    logic           pop;
    logic signed [cmwf_pkg::DRIVE_W-1:0] push_drive;
    logic signed [cmwf_pkg::DRIVE_W-1:0] q_drive;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slave_address    <= 8'd1;
            cfg_reg.register_address <= 16'd0;
            cfg_reg.channel_min      <= 16'sd1000;
            cfg_reg.channel_max      <= 16'sd2000;
            cfg_reg.channel_mid      <= 16'sd1500;
            cfg_reg.deadband         <= 15'd20;
            cfg_reg.drive_scale      <= 8'd20;
            cfg_reg.drive_limit      <= 15'd1000;
        end
        else if (cfg_we)
        begin
            unique case (cmwf_pkg::cfg_idx_t'(cfg_index))
                cmwf_pkg::REG_SLAVE_ADDRESS:    cfg_reg.slave_address    <= cfg_wdata[7:0];
                cmwf_pkg::REG_REGISTER_ADDRESS: cfg_reg.register_address <= cfg_wdata;
                cmwf_pkg::REG_CHANNEL_MIN:      cfg_reg.channel_min      <= $signed(cfg_wdata);
                cmwf_pkg::REG_CHANNEL_MAX:      cfg_reg.channel_max      <= $signed(cfg_wdata);
                cmwf_pkg::REG_CHANNEL_MID:      cfg_reg.channel_mid      <= $signed(cfg_wdata);
                cmwf_pkg::REG_DEADBAND:         cfg_reg.deadband         <= cfg_wdata[14:0];
                cmwf_pkg::REG_DRIVE_SCALE:      cfg_reg.drive_scale      <= cfg_wdata[7:0];
                cmwf_pkg::REG_DRIVE_LIMIT:      cfg_reg.drive_limit      <= cfg_wdata[14:0];
            endcase
        end
    end

    cmwf_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cmd        (cmd),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_drive (push_drive)
    );

    cmwf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_valid),
        .push_drive (push_drive),
        .full       (q_full),
        .q_valid    (q_valid),
        .q_drive    (q_drive),
        .pop        (pop)
    );

    cmwf_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_drive (q_drive),
        .pop     (pop),
        .frame   (frame)
    );

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench for channel_to_modbus_write_framer_unit
// commands in, modbus frame bytes out; depends on cmwf_pkg and the cmwf interfaces
`timescale 1ns / 1ps

module tb_top;

    localparam logic KIND_CHANNEL = 1'b0;
    localparam logic KIND_STOP    = 1'b1;
    localparam int   CYCLE_LIMIT  = 1500000;
    localparam int   HOLD_CYCLES  = 400;

    typedef struct {
        logic        kind;
        logic [15:0] value;
    } command_t;

    typedef struct {
        logic [7:0]  frame_byte;
        logic [2:0]  byte_index;
        logic        last_byte;
        logic [15:0] drive_value;
    } frame_entry_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_wdata;

    cmwf_cmd_if  cmd ();
    cmwf_byte_if frame ();

    command_t       cmd_pending[$];
    frame_entry_t   expected_bytes[$];
    cmwf_pkg::cfg_t cfg_now;
    logic [15:0]    held_drive;
    int             errors = 0;
    int             cycle_cnt = 0;
    int             accepted_cnt;
    int             src_gap;
    int             sink_stall;
    int             hold_left;
    int             holds_done;
    logic           quiet;
    int             quiet_left;

    channel_to_modbus_write_framer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .frame     (frame)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic logic [15:0] drive_from_channel(input logic [15:0] raw);
        int v;
        int dev;
        int t;
        int lim;
        v = $signed(raw);
        lim = int'(cfg_now.drive_limit);
        if (v > int'($signed(cfg_now.channel_max)))
        begin
            v = $signed(cfg_now.channel_max);
        end
        else if (v < int'($signed(cfg_now.channel_min)))
        begin
            v = $signed(cfg_now.channel_min);
        end
        else
        begin
            dev = v - int'($signed(cfg_now.channel_mid));
            if (dev < 0)
            begin
                dev = -dev;
            end
            if (dev < int'(cfg_now.deadband))
            begin
                v = $signed(cfg_now.channel_mid);
            end
        end
        t = (v - int'(cmwf_pkg::CHANNEL_CENTER)) / 9;
        t = t * int'(cfg_now.drive_scale);
        if (t > lim)
        begin
            t = lim;
        end
        if (t < -lim)
        begin
            t = -lim;
        end
        return 16'(t);
    endfunction

    function automatic void predict_frame(input logic kind, input logic [15:0] raw);
        logic [7:0]   bytes [8];
        logic [15:0]  crc;
        frame_entry_t e;
        held_drive = (kind == KIND_STOP) ? 16'h0000 : drive_from_channel(raw);
        bytes[cmwf_pkg::BYTE_SLAVE]    = cfg_now.slave_address;
        bytes[cmwf_pkg::BYTE_FUNC]     = cmwf_pkg::FUNC_WRITE_SINGLE;
        bytes[cmwf_pkg::BYTE_REG_HI]   = cfg_now.register_address[15:8];
        bytes[cmwf_pkg::BYTE_REG_LO]   = cfg_now.register_address[7:0];
        bytes[cmwf_pkg::BYTE_VALUE_HI] = held_drive[15:8];
        bytes[cmwf_pkg::BYTE_VALUE_LO] = held_drive[7:0];
        crc = cmwf_pkg::CRC_SEED;
        for (int i = 0; i < 6; i++)
        begin
            crc = crc ^ {8'h00, bytes[i]};
            for (int b = 0; b < 8; b++)
            begin
                crc = crc[0] ? ((crc >> 1) ^ cmwf_pkg::CRC_POLY) : (crc >> 1);
            end
        end
        bytes[cmwf_pkg::BYTE_CRC_LO] = crc[7:0];
        bytes[cmwf_pkg::BYTE_CRC_HI] = crc[15:8];
        for (int i = 0; i < 8; i++)
        begin
            e.frame_byte  = bytes[i];
            e.byte_index  = 3'(i);
            e.last_byte   = (i == 7);
            e.drive_value = held_drive;
            expected_bytes.push_back(e);
        end
    endfunction

    task automatic check_frame_byte();
        frame_entry_t e;
        if (expected_bytes.size() == 0)
        begin
            report_mismatch($sformatf("unexpected frame byte %02h", frame.frame_byte));
            return;
        end
        e = expected_bytes.pop_front();
        if (frame.frame_byte !== e.frame_byte)
        begin
            report_mismatch($sformatf("byte %0d frame_byte %02h, want %02h",
                                      e.byte_index, frame.frame_byte, e.frame_byte));
        end
        if (frame.byte_index !== e.byte_index)
        begin
            report_mismatch($sformatf("byte_index %0d, want %0d",
                                      frame.byte_index, e.byte_index));
        end
        if (frame.last_byte !== e.last_byte)
        begin
            report_mismatch($sformatf("byte %0d last_byte %b, want %b",
                                      e.byte_index, frame.last_byte, e.last_byte));
        end
        if (frame.drive_value !== e.drive_value)
        begin
            report_mismatch($sformatf("byte %0d drive_value %04h, want %04h",
                                      e.byte_index, frame.drive_value, e.drive_value));
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 90)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 80);
    endfunction

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd.valid     <= 1'b0;
            cmd.kind      <= KIND_CHANNEL;
            cmd.raw_value <= 16'h0000;
            src_gap       <= 0;
            accepted_cnt  <= 0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                predict_frame(cmd.kind, cmd.raw_value);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!cmd.valid || cmd.ready)
            begin
                if (src_gap != 0)
                begin
                    cmd.valid <= 1'b0;
                    src_gap   <= src_gap - 1;
                end
                else if (cmd_pending.size() != 0)
                begin
                    command_t c;
                    c = cmd_pending.pop_front();
                    cmd.valid     <= 1'b1;
                    cmd.kind      <= c.kind;
                    cmd.raw_value <= c.value;
                    if (!quiet && $urandom_range(0, 99) < 35)
                    begin
                        src_gap <= pick_gap();
                    end
                end
                else
                begin
                    cmd.valid <= 1'b0;
                end
            end
        end
    end

    // frame byte monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame.ready <= 1'b0;
            sink_stall  <= 0;
        end
        else
        begin
            if (frame.valid && frame.ready)
            begin
                check_frame_byte();
            end
            if (hold_left != 0)
            begin
                frame.ready <= 1'b0;
            end
            else if (sink_stall != 0)
            begin
                frame.ready <= 1'b0;
                sink_stall  <= sink_stall - 1;
            end
            else
            begin
                frame.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 99) < 15)
                begin
                    sink_stall <= pick_gap();
                end
            end
        end
    end

    // long receiver hold so the command side backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            holds_done <= 0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if ((holds_done == 0 && accepted_cnt >= 60) ||
                 (holds_done == 1 && accepted_cnt >= 250))
        begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // stretches where neither side idles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet      <= 1'b0;
            quiet_left <= 200;
        end
        else if (quiet_left != 0)
        begin
            quiet_left <= quiet_left - 1;
        end
        else
        begin
            quiet      <= !quiet;
            quiet_left <= quiet ? $urandom_range(150, 500) : $urandom_range(60, 200);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic cmwf_pkg::cfg_t default_config();
        cmwf_pkg::cfg_t c;
        c.slave_address    = 8'd1;
        c.register_address = 16'd0;
        c.channel_min      = 16'sd1000;
        c.channel_max      = 16'sd2000;
        c.channel_mid      = 16'sd1500;
        c.deadband         = 15'd20;
        c.drive_scale      = 8'd20;
        c.drive_limit      = 15'd1000;
        return c;
    endfunction

    function automatic cmwf_pkg::cfg_t random_config();
        cmwf_pkg::cfg_t c;
        int             a;
        int             b;
        c.slave_address    = 8'($urandom);
        c.register_address = 16'($urandom);
        if ($urandom_range(0, 3) == 0)
        begin
            c.channel_min = 16'($urandom);
            c.channel_max = 16'($urandom);
            c.channel_mid = 16'($urandom);
            c.deadband    = 15'($urandom);
            c.drive_limit = 15'($urandom);
        end
        else
        begin
            a = $urandom_range(0, 1500);
            b = $urandom_range(1500, 3000);
            c.channel_min = 16'(a);
            c.channel_max = 16'(b);
            c.channel_mid = 16'($urandom_range(a, b));
            c.deadband    = 15'($urandom_range(0, 200));
            c.drive_limit = 15'($urandom_range(0, 4000));
        end
        c.drive_scale = 8'($urandom);
        return c;
    endfunction

    task automatic apply_config(input cmwf_pkg::cfg_t c);
        logic [15:0]        data;
        cmwf_pkg::cfg_idx_t idx;
        cfg_now = c;
        for (int i = 0; i < 8; i++)
        begin
            idx = cmwf_pkg::cfg_idx_t'(i);
            case (idx)
                cmwf_pkg::REG_SLAVE_ADDRESS:    data = {8'h00, c.slave_address};
                cmwf_pkg::REG_REGISTER_ADDRESS: data = c.register_address;
                cmwf_pkg::REG_CHANNEL_MIN:      data = c.channel_min;
                cmwf_pkg::REG_CHANNEL_MAX:      data = c.channel_max;
                cmwf_pkg::REG_CHANNEL_MID:      data = c.channel_mid;
                cmwf_pkg::REG_DEADBAND:         data = {1'b0, c.deadband};
                cmwf_pkg::REG_DRIVE_SCALE:      data = {8'h00, c.drive_scale};
                default:                        data = {1'b0, c.drive_limit};
            endcase
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= data;
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_command(input logic kind, input logic [15:0] value);
        command_t c;
        c.kind  = kind;
        c.value = value;
        cmd_pending.push_back(c);
    endtask

    function automatic logic [15:0] pick_channel();
        int lo;
        int hi;
        int r;
        int mid;
        int dead;
        lo   = $signed(cfg_now.channel_min);
        hi   = $signed(cfg_now.channel_max);
        mid  = $signed(cfg_now.channel_mid);
        dead = int'(cfg_now.deadband);
        if (lo > hi)
        begin
            r  = lo;
            lo = hi;
            hi = r;
        end
        r = $urandom_range(0, 9);
        if (r < 3)
        begin
            return 16'($urandom);
        end
        if (r < 5)
        begin
            lo = mid - dead - 3;
            hi = mid + dead + 3;
        end
        else
        begin
            lo = lo - 100;
            hi = hi + 100;
        end
        if (lo < -32768)
        begin
            lo = -32768;
        end
        if (hi > 32767)
        begin
            hi = 32767;
        end
        return 16'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            queue_command(($urandom_range(0, 9) == 0) ? KIND_STOP : KIND_CHANNEL,
                          pick_channel());
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (cmd_pending.size() != 0 || cmd.valid || expected_bytes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (12) @(posedge clk);
    endtask

    initial
    begin
        cmwf_pkg::cfg_t c;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = cmwf_pkg::REG_SLAVE_ADDRESS;
        cfg_wdata     = 16'h0000;
        cmd.valid     = 1'b0;
        cmd.kind      = KIND_CHANNEL;
        cmd.raw_value = 16'h0000;
        frame.ready   = 1'b0;
        cfg_now       = default_config();
        held_drive    = 16'h0000;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: bounds, deadband edges, truncation, stop
        queue_command(KIND_STOP, 16'hFFFF);
        queue_command(KIND_CHANNEL, 16'h0000);
        queue_command(KIND_CHANNEL, 16'hFFFF);
        queue_command(KIND_CHANNEL, 16'h8000);
        queue_command(KIND_CHANNEL, 16'h7FFF);
        queue_command(KIND_CHANNEL, 16'd999);
        queue_command(KIND_CHANNEL, 16'd1000);
        queue_command(KIND_CHANNEL, 16'd2000);
        queue_command(KIND_CHANNEL, 16'd2001);
        queue_command(KIND_CHANNEL, 16'd1481);
        queue_command(KIND_CHANNEL, 16'd1480);
        queue_command(KIND_CHANNEL, 16'd1519);
        queue_command(KIND_CHANNEL, 16'd1520);
        queue_command(KIND_CHANNEL, 16'd1528);
        queue_command(KIND_CHANNEL, 16'd1529);
        queue_command(KIND_CHANNEL, 16'd1471);
        queue_command(KIND_CHANNEL, 16'h5555);
        queue_command(KIND_STOP, 16'hAAAA);
        queue_random(100);
        wait_drained();

        c.slave_address    = 8'hFF;
        c.register_address = 16'hFFFF;
        c.channel_min      = 16'sh8000;
        c.channel_max      = 16'sh7FFF;
        c.channel_mid      = 16'sd0;
        c.deadband         = 15'h7FFF;
        c.drive_scale      = 8'hFF;
        c.drive_limit      = 15'h7FFF;
        apply_config(c);
        queue_random(60);
        wait_drained();

        // minimum above maximum, no deadband
        c.slave_address    = 8'h00;
        c.register_address = 16'h1234;
        c.channel_min      = 16'sd2000;
        c.channel_max      = 16'sd1000;
        c.channel_mid      = 16'sd1500;
        c.deadband         = 15'd0;
        c.drive_scale      = 8'd7;
        c.drive_limit      = 15'd32767;
        apply_config(c);
        queue_command(KIND_CHANNEL, 16'd2500);
        queue_command(KIND_CHANNEL, 16'd500);
        queue_command(KIND_CHANNEL, 16'd1500);
        queue_random(50);
        wait_drained();

        // zero scale and zero limit
        c.slave_address    = 8'h80;
        c.register_address = 16'h0000;
        c.channel_min      = 16'sh8000;
        c.channel_max      = 16'sh7FFF;
        c.channel_mid      = 16'sd1500;
        c.deadband         = 15'd0;
        c.drive_scale      = 8'd0;
        c.drive_limit      = 15'd0;
        apply_config(c);
        queue_command(KIND_CHANNEL, 16'd1500);
        queue_command(KIND_CHANNEL, 16'd1501);
        queue_random(40);
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            apply_config(random_config());
            queue_random(50);
            wait_drained();
        end

        apply_config(default_config());
        queue_random(15);
        wait_drained();

        repeat (20) @(posedge clk);
        if (errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/cmwf_pkg.sv
sv/cmwf_if.sv
sv/cmwf_front.sv
sv/cmwf_queue.sv
sv/cmwf_back.sv
sv/channel_to_modbus_write_framer_unit.sv
test/tb_top.sv
